// ===== hdl/tccs_pkg.sv =====
// ---------------------------------------------------------------------------
// tccs_pkg: shared types and constants of the text console engine
// Operation codes, character codes, cell constants and the command and
// status bundles exchanged between controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package tccs_pkg;

   // default screen geometry
   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 25;

   // payload field widths
   localparam int OP_W    = 2;
   localparam int CHAR_W  = 8;
   localparam int ATTR_W  = 8;
   localparam int RROW_W  = 5;
   localparam int RCOL_W  = 7;
   localparam int CELL_W  = 16;
   localparam int REQ_W   = 32;
   localparam int RSP_W   = 32;

   // operation codes
   localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   // character and cell codes
   localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_BS     = 8'h08;
   localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [ATTR_W-1:0] TEXT_ATTR = 8'h07;
   localparam logic [CELL_W-1:0] BLANK_CELL = {TEXT_ATTR, CH_SPACE};

   // controller to datapath
   typedef struct packed {
      logic capture;   // take the request beat into the item registers
      logic init;      // home cursor, zero scroll base, arm a blank fill
      logic exec;      // carry out the captured operation
      logic sweep;     // write the fill value at the sweep position, advance
      logic load_out;  // load the result register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [OP_W-1:0] op;        // captured operation
      logic            scroll;    // put operation runs past the last row
      logic            last_col;  // sweep sits on the last column
      logic            last_row;  // sweep sits on the last row
   } status_type;

endpackage

`default_nettype wire

// ===== hdl/tccs_ctrl.sv =====
// ---------------------------------------------------------------------------
// tccs_ctrl: sequencer of the text console engine
// Runs the power-up fill, takes one request at a time, steps the fill and
// row-blank sweeps and hands the result to the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module tccs_ctrl
   import tccs_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire         rsp_tready,
   output logic        rsp_tvalid,
   output cmd_type     cmd,
   input  status_type  status
);

   localparam logic [2:0] S_INIT     = 3'd0;
   localparam logic [2:0] S_INITFILL = 3'd1;
   localparam logic [2:0] S_IDLE     = 3'd2;
   localparam logic [2:0] S_EXEC     = 3'd3;
   localparam logic [2:0] S_FILL     = 3'd4;
   localparam logic [2:0] S_BLANK    = 3'd5;
   localparam logic [2:0] S_FINISH   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // decode state into datapath commands and the next state
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         S_INIT: begin
            cmd.init = 1'b1;
            state_in = S_INITFILL;
         end
         S_INITFILL: begin
            cmd.sweep = 1'b1;
            if (status.last_col && status.last_row) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (status.op == OP_CLEAR) begin
               state_in = S_FILL;
            end else if (status.op == OP_PUT && status.scroll) begin
               state_in = S_BLANK;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FILL: begin
            cmd.sweep = 1'b1;
            if (status.last_col && status.last_row) begin
               state_in = S_FINISH;
            end
         end
         S_BLANK: begin
            cmd.sweep = 1'b1;
            if (status.last_col) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   // hold state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/tccs_datapath.sv =====
// ---------------------------------------------------------------------------
// tccs_datapath: screen store, cursor and sweep logic
// Holds the screen memory addressed through a rotating row base, the
// cursor, the sweep counters for fill and row blanking, and the result
// register.
// ---------------------------------------------------------------------------
`default_nettype none

module tccs_datapath
   import tccs_pkg::*;
#(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS
) (
   input  wire              clock,
   input  wire              reset,
   input  wire [REQ_W-1:0]  req_tdata,
   input  wire [OP_W-1:0]   req_tuser,
   output logic [RSP_W-1:0] rsp_tdata,
   input  cmd_type          cmd,
   output status_type       status
);

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int ADDR_W = $clog2(CELLS);

   // captured item
   logic [OP_W-1:0]   op_ff;
   logic [CHAR_W-1:0] char_ff;
   logic [ATTR_W-1:0] attr_ff;
   logic [ROW_W-1:0]  rrow_ff;
   logic [COL_W-1:0]  rcol_ff;
   logic              in_range_ff;

   // cursor, scroll base, sweep
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ROW_W-1:0]  base_ff, base_in;
   logic [ROW_W-1:0]  sweep_row_ff, sweep_row_in;
   logic [COL_W-1:0]  sweep_col_ff, sweep_col_in;
   logic [CELL_W-1:0] fill_ff, fill_in;

   // memory
   logic [CELL_W-1:0] screen_mem [CELLS];
   logic [CELL_W-1:0] rd_data_ff;
   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_addr;
   logic [CELL_W-1:0] mem_wdata;
   logic [ROW_W-1:0]  addr_row;
   logic [COL_W-1:0]  addr_col;

   // put decode
   logic              is_lf, is_cr, is_bs, is_text;
   logic              last_cur_col;
   logic [COL_W-1:0]  bs_col;
   logic [ROW_W:0]    row_next;
   logic              scroll;
   logic              rsp_read;

   // result register
   logic [CELL_W-1:0] out_cell_ff;
   logic [RCOL_W-1:0] out_col_ff;
   logic [RROW_W-1:0] out_row_ff;

   // map a screen row onto a memory row through the scroll base
   function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lrow,
                                                 input logic [ROW_W-1:0] base);
      logic [ROW_W:0] sum;
      sum = {1'b0, lrow} + {1'b0, base};
      if (int'(sum) >= ROWS) begin
         sum = sum - (ROW_W+1)'(ROWS);
      end
      return sum[ROW_W-1:0];
   endfunction

   // capture the request beat
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= req_tuser;
         char_ff     <= req_tdata[7:0];
         attr_ff     <= req_tdata[15:8];
         in_range_ff <= (int'(req_tdata[20:16]) < ROWS) && (int'(req_tdata[27:21]) < COLUMNS);
         if ((int'(req_tdata[20:16]) < ROWS) && (int'(req_tdata[27:21]) < COLUMNS)) begin
            rrow_ff <= ROW_W'(req_tdata[20:16]);
            rcol_ff <= COL_W'(req_tdata[27:21]);
         end else begin
            rrow_ff <= '0;
            rcol_ff <= '0;
         end
      end
   end

   // decode the put character and the cursor move
   assign is_lf        = (char_ff == CH_LF);
   assign is_cr        = (char_ff == CH_CR);
   assign is_bs        = (char_ff == CH_BS);
   assign is_text      = !is_lf && !is_cr && !is_bs;
   assign last_cur_col = (col_ff == COL_W'(COLUMNS - 1));
   assign bs_col       = (col_ff != '0) ? col_ff - COL_W'(1) : col_ff;
   assign row_next     = {1'b0, row_ff} + (ROW_W+1)'(1);
   assign scroll       = (is_lf || (is_text && last_cur_col)) &&
                         (row_next == (ROW_W+1)'(ROWS));

   assign status.op       = op_ff;
   assign status.scroll   = scroll;
   assign status.last_col = (sweep_col_ff == COL_W'(COLUMNS - 1));
   assign status.last_row = (sweep_row_ff == ROW_W'(ROWS - 1));

   // pick the memory address and write data
   always_comb begin
      addr_row  = phys_row(row_ff, base_ff);
      addr_col  = col_ff;
      mem_wdata = {TEXT_ATTR, char_ff};
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      if (cmd.sweep) begin
         addr_row  = sweep_row_ff;
         addr_col  = sweep_col_ff;
         mem_wdata = fill_ff;
         mem_we    = 1'b1;
      end else if (cmd.exec && op_ff == OP_READ) begin
         addr_row = phys_row(rrow_ff, base_ff);
         addr_col = rcol_ff;
         mem_re   = 1'b1;
      end else if (cmd.exec && op_ff == OP_PUT) begin
         if (is_bs) begin
            addr_col  = bs_col;
            mem_wdata = BLANK_CELL;
            mem_we    = 1'b1;
         end else if (is_text) begin
            mem_we = 1'b1;
         end
      end
   end

   assign mem_addr = ADDR_W'(addr_row) * ADDR_W'(COLUMNS) + ADDR_W'(addr_col);

   // screen store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= screen_mem[mem_addr];
      end
   end

   // next cursor, base and sweep values
   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      base_in      = base_ff;
      sweep_row_in = sweep_row_ff;
      sweep_col_in = sweep_col_ff;
      fill_in      = fill_ff;
      if (cmd.init) begin
         col_in       = '0;
         row_in       = '0;
         base_in      = '0;
         sweep_row_in = '0;
         sweep_col_in = '0;
         fill_in      = BLANK_CELL;
      end else if (cmd.exec) begin
         case (op_ff)
            OP_CLEAR: begin
               col_in       = '0;
               row_in       = '0;
               base_in      = '0;
               sweep_row_in = '0;
               sweep_col_in = '0;
               fill_in      = {attr_ff, CH_SPACE};
            end
            OP_PUT: begin
               if (scroll) begin
                  // retire the top memory row, blank it as the new bottom row
                  col_in       = '0;
                  row_in       = ROW_W'(ROWS - 1);
                  base_in      = (base_ff == ROW_W'(ROWS - 1)) ? '0 : base_ff + ROW_W'(1);
                  sweep_row_in = base_ff;
                  sweep_col_in = '0;
                  fill_in      = BLANK_CELL;
               end else if (is_lf) begin
                  col_in = '0;
                  row_in = row_next[ROW_W-1:0];
               end else if (is_cr) begin
                  col_in = '0;
               end else if (is_bs) begin
                  col_in = bs_col;
               end else if (last_cur_col) begin
                  col_in = '0;
                  row_in = row_next[ROW_W-1:0];
               end else begin
                  col_in = col_ff + COL_W'(1);
               end
            end
            default: begin
            end
         endcase
      end else if (cmd.sweep) begin
         if (status.last_col) begin
            sweep_col_in = '0;
            sweep_row_in = status.last_row ? '0 : sweep_row_ff + ROW_W'(1);
         end else begin
            sweep_col_in = sweep_col_ff + COL_W'(1);
         end
      end
   end

   // hold cursor and base; sweep and fill are payload
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         base_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         base_ff <= base_in;
      end
      sweep_row_ff <= sweep_row_in;
      sweep_col_ff <= sweep_col_in;
      fill_ff      <= fill_in;
   end

   // load the result register
   assign rsp_read = (op_ff == OP_READ) && in_range_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_cell_ff <= rsp_read ? rd_data_ff : '0;
         out_col_ff  <= RCOL_W'(col_ff);
         out_row_ff  <= RROW_W'(row_ff);
      end
   end

   assign rsp_tdata = {4'b0000, out_row_ff, out_col_ff, out_cell_ff};

endmodule

`default_nettype wire

// ===== hdl/text_console_cursor_scroll.sv =====
// ---------------------------------------------------------------------------
// text_console_cursor_scroll: text-mode character engine
// Screen store of COLUMNS x ROWS cells with cursor, put, clear and read.
// ---------------------------------------------------------------------------
//  channel | ports          | beat contents
//  --------+----------------+----------------------------------------------
//  request | req_t*  (in)   | tuser: operation; tdata: char, attr, row, col
//  result  | rsp_t*  (out)  | tdata: cell_value, cursor_column, cursor_row
//
//  A plain put, a read or an unused code passes through the accept
//  state, one memory access and the result load. The result beat turns
//  valid as the result register is loaded.
//  A put that scrolls then sweeps a row: the row base rotates and the
//  new bottom row is blanked one cell a cycle on the single write port.
//  A clear then sweeps the whole screen, one cell a cycle.
//  After reset a fill pass blanks the screen before req_tready rises. A
//  stalled result holds in the output register while the next request is
//  accepted and worked on.
// ---------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_scroll
   import tccs_pkg::*;
#(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_tvalid,
   output logic             req_tready,
   input  wire [REQ_W-1:0]  req_tdata,  // character, fill_attribute, read_row, read_column
   input  wire [OP_W-1:0]   req_tuser,  // operation
   output logic             rsp_tvalid,
   input  wire              rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata   // cell_value, cursor_column, cursor_row
);

   cmd_type    cmd;
   status_type status;

   tccs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .cmd        (cmd),
      .status     (status)
   );

   tccs_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

`default_nettype wire

// ===== hdl/tccs_checker.sv =====
// ---------------------------------------------------------------------------
// tccs_checker: port-level checks of the text console engine
// Watches the request and result channels and flags cursor values off the
// screen, items taken too early or too close together, and lost results.
// ---------------------------------------------------------------------------
`default_nettype none

module tccs_checker
   import tccs_pkg::*;
#(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS
) (
   input wire             clock,
   input wire             reset,
   input wire             req_tvalid,
   input wire             req_tready,
   input wire             rsp_tvalid,
   input wire             rsp_tready,
   input wire [RSP_W-1:0] rsp_tdata
);

   // reset starts the fill pass, no beat is taken right after it
   a_no_take_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request taken during power-up fill");

   // one item at a time: no accept in the cycle after an accept
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while an item is in work");

   // a stalled result holds its beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed or dropped");

   // reported cursor stays on the screen
   a_cursor_on_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((int'(rsp_tdata[22:16]) < COLUMNS) && (int'(rsp_tdata[27:23]) < ROWS)))
      else $error("cursor reported off screen");

endmodule

bind text_console_cursor_scroll tccs_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_tccs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ===== bench/tb_text_console_cursor_scroll.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_text_console_cursor_scroll: bench for the text console engine
// Drives put, clear, read and unused-code beats with random gaps on both
// channels. A scoreboard class keeps its own screen image and cursor, works
// out the result of every accepted request and checks each result beat
// field by field in order.
// ---------------------------------------------------------------------------

module tb_text_console_cursor_scroll;
   import tccs_pkg::*;

   localparam int SCR_COLS    = DEF_COLUMNS;
   localparam int SCR_ROWS    = DEF_ROWS;
   localparam int CELL_COUNT  = SCR_COLS * SCR_ROWS;
   localparam int IDLE_PCT    = 37;
   localparam int RANDOM_BEATS = 1150;
   localparam int CYCLE_LIMIT = 1_500_000;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // one result beat as the console reports it
   typedef struct packed {
      logic [CELL_W-1:0] cell_val;
      logic [RCOL_W-1:0] col;
      logic [RROW_W-1:0] row;
   } console_view_type;

   // -------------------------------------------------------------------------
   // scoreboard: screen image, cursor and the queue of awaited result beats
   // -------------------------------------------------------------------------
   class console_scoreboard;
      logic [CELL_W-1:0] screen [CELL_COUNT];
      int                cur_col;
      int                cur_row;
      console_view_type  awaited_q [$];
      int                errors;

      function new();
         foreach (screen[i]) screen[i] = BLANK_CELL;
         cur_col = 0;
         cur_row = 0;
         errors  = 0;
      endfunction

      // apply one accepted request beat and queue the result it must give
      function void note_request(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                                 logic [ATTR_W-1:0] attr, logic [RROW_W-1:0] rd_row,
                                 logic [RCOL_W-1:0] rd_col);
         console_view_type view;
         int               pos;
         view.cell_val = '0;
         if (op == OP_PUT) begin
            pos = cur_row * SCR_COLS + cur_col;
            if (ch == CH_LF) begin
               cur_col = 0;
               cur_row++;
            end else if (ch == CH_CR) begin
               cur_col = 0;
            end else if (ch == CH_BS) begin
               // backspace never leaves the current row
               if (cur_col > 0) cur_col--;
               screen[cur_row * SCR_COLS + cur_col] = BLANK_CELL;
            end else begin
               screen[pos] = {TEXT_ATTR, ch};
               cur_col++;
               if (cur_col >= SCR_COLS) begin
                  cur_col = 0;
                  cur_row++;
               end
            end
            // scroll up one row once the cursor runs off the bottom
            if (cur_row >= SCR_ROWS) begin
               for (int i = 0; i < CELL_COUNT - SCR_COLS; i++)
                  screen[i] = screen[i + SCR_COLS];
               for (int i = CELL_COUNT - SCR_COLS; i < CELL_COUNT; i++)
                  screen[i] = BLANK_CELL;
               cur_row = SCR_ROWS - 1;
               cur_col = 0;
            end
         end else if (op == OP_CLEAR) begin
            foreach (screen[i]) screen[i] = {attr, CH_SPACE};
            cur_col = 0;
            cur_row = 0;
         end else if (op == OP_READ) begin
            if (rd_row < SCR_ROWS && rd_col < SCR_COLS)
               view.cell_val = screen[rd_row * SCR_COLS + rd_col];
         end
         view.col = cur_col[RCOL_W-1:0];
         view.row = cur_row[RROW_W-1:0];
         awaited_q.push_back(view);
      endfunction

      // compare one result beat with the oldest awaited one
      function void check_response(logic [RSP_W-1:0] data);
         console_view_type exp_v;
         console_view_type got;
         got.cell_val = data[15:0];
         got.col      = data[22:16];
         got.row      = data[27:23];
         if (awaited_q.size() == 0) begin
            $display("%0t: unexpected result beat %h", $time, data);
            errors++;
         end else begin
            exp_v = awaited_q.pop_front();
            if (got.cell_val !== exp_v.cell_val) begin
               $display("%0t: cell_value expected %h actual %h",
                        $time, exp_v.cell_val, got.cell_val);
               errors++;
            end
            if (got.col !== exp_v.col) begin
               $display("%0t: cursor_column expected %0d actual %0d",
                        $time, exp_v.col, got.col);
               errors++;
            end
            if (got.row !== exp_v.row) begin
               $display("%0t: cursor_row expected %0d actual %0d",
                        $time, exp_v.row, got.row);
               errors++;
            end
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic [OP_W-1:0]  req_tuser;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;

   console_scoreboard sb = new();
   bit                steady;     // no idling on either side while set
   int unsigned       cycles;

   text_console_cursor_scroll i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // count cycles and stop a hung run
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // result side: check accepted beats, stall at random
   initial rsp_tready = 1'b0;
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tdata);
      rsp_tready <= steady || reset ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
   end

   // send one request beat after a random gap and note it once accepted
   task automatic send_beat(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                            logic [ATTR_W-1:0] attr, logic [RROW_W-1:0] rd_row,
                            logic [RCOL_W-1:0] rd_col);
      int gap;
      gap = 0;
      while (!steady && $urandom_range(99) < IDLE_PCT) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, rd_col, rd_row, attr, ch};
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, ch, attr, rd_row, rd_col);
   endtask

   // hold the sender until every awaited result has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.awaited_q.size() != 0);
   endtask

   initial begin
      int               lf_pct;
      int               pick;
      logic [OP_W-1:0]  op;
      logic [CHAR_W-1:0] ch;
      logic [RROW_W-1:0] rd_row;
      logic [RCOL_W-1:0] rd_col;

      reset      = 1'b1;
      steady     = 1'b0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_PUT;
      lf_pct     = 10;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: reads at the corners and out of range, control codes,
      // backspace at column 0, unused code, clears with extreme attributes
      send_beat(OP_READ,  8'h00, 8'h00, 5'd0,  7'd0);
      send_beat(OP_READ,  8'h00, 8'h00, 5'd24, 7'd79);
      send_beat(OP_READ,  8'hFF, 8'hFF, 5'd31, 7'd127);
      send_beat(OP_READ,  8'h00, 8'h00, 5'd25, 7'd0);
      send_beat(OP_READ,  8'h00, 8'h00, 5'd0,  7'd80);
      send_beat(OP_PUT,   8'h41, 8'h00, 5'd0,  7'd0);
      send_beat(OP_PUT,   8'h00, 8'h00, 5'd0,  7'd0);
      send_beat(OP_PUT,   8'hFF, 8'h00, 5'd0,  7'd0);
      send_beat(OP_READ,  8'h00, 8'h00, 5'd0,  7'd2);
      send_beat(OP_PUT,   CH_BS, 8'h00, 5'd0,  7'd0);
      send_beat(OP_READ,  8'h00, 8'h00, 5'd0,  7'd2);
      send_beat(OP_PUT,   CH_CR, 8'h00, 5'd0,  7'd0);
      send_beat(OP_PUT,   CH_BS, 8'h00, 5'd0,  7'd0);
      send_beat(OP_READ,  8'h00, 8'h00, 5'd0,  7'd0);
      send_beat(OP_PUT,   CH_LF, 8'h00, 5'd0,  7'd0);
      send_beat(OP_UNUSED, 8'hFF, 8'hFF, 5'd31, 7'd127);
      send_beat(OP_CLEAR, 8'h00, 8'hFF, 5'd0,  7'd0);
      send_beat(OP_READ,  8'h00, 8'h00, 5'd12, 7'd40);
      send_beat(OP_PUT,   8'h7E, 8'h00, 5'd0,  7'd0);
      send_beat(OP_CLEAR, 8'h00, 8'h00, 5'd0,  7'd0);
      send_beat(OP_READ,  8'h00, 8'h00, 5'd24, 7'd79);
      send_beat(OP_PUT,   8'h80, 8'h00, 5'd0,  7'd0);
      send_beat(OP_READ,  8'h00, 8'h00, 5'd0,  7'd0);
      drain_results();

      // random: text runs with newlines, reads, rare clears and unused codes
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         // alternate long lines that wrap with newline-heavy stretches
         if (n % 100 == 0) lf_pct = $urandom_range(1) ? 18 : 1;
         steady = (n >= 500 && n < 650);
         if (n == 700) drain_results();
         pick   = $urandom_range(999);
         ch     = CHAR_W'($urandom_range(255));
         rd_row = RROW_W'($urandom_range(SCR_ROWS - 1));
         rd_col = RCOL_W'($urandom_range(SCR_COLS - 1));
         if (pick < 700) begin
            op   = OP_PUT;
            pick = $urandom_range(99);
            if (pick < lf_pct) ch = CH_LF;
            else if (pick < lf_pct + 4) ch = CH_CR;
            else if (pick < lf_pct + 12) ch = CH_BS;
         end else if (pick < 960) begin
            op = OP_READ;
            if ($urandom_range(9) == 0) begin
               rd_row = RROW_W'($urandom_range(31));
               rd_col = RCOL_W'($urandom_range(127));
            end
         end else if (pick < 980) begin
            op = OP_UNUSED;
            rd_row = RROW_W'($urandom_range(31));
            rd_col = RCOL_W'($urandom_range(127));
         end else if (pick < 986) begin
            op = OP_CLEAR;
         end else begin
            op = OP_READ;
         end
         send_beat(op, ch, ATTR_W'($urandom_range(255)), rd_row, rd_col);
      end
      steady = 1'b0;

      // wait for the tail and watch for stray beats
      drain_results();
      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.awaited_q.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
